// File: sv/recent_digest_dedup_window_top_macros.svh
// Assertion macros for the digest window block
`ifndef RECENT_DIGEST_DEDUP_WINDOW_TOP_MACROS_SVH
`define RECENT_DIGEST_DEDUP_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RDDW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RDDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rddw_pkg.sv
// Shared types and constants for the digest window block
package rddw_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DIGEST_W   = 256;
  localparam int WORD_W     = 64;
  localparam int TAG_W      = 64;
  localparam int TIME_W     = 48;
  localparam int EXP_W      = TIME_W + 1;
  localparam int WIN_W      = 32;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam logic [WIN_W-1:0] WINDOW_RST = 32'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_LOOKUP = 3'd1,
    MODE_OLDEST = 3'd2,
    MODE_ROTATE = 3'd3,
    MODE_POP    = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_EXP_RD,
    S_EXP_CHK,
    S_ROT_WR,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [DIGEST_W-1:0] digest;
    logic [TIME_W-1:0]   arrival;
    logic [TAG_W-1:0]    tag;
  } entry_t;

endpackage

// File: sv/recent_digest_dedup_window_top.sv
// Recent digest window: ring of digests with arrival time and tag, served by a small sequencer
//
// Holds up to DEPTH entries (digest, arrival time, tag) in one single-port-read memory with a
// registered read. One transaction is worked on at a time; in_stall is high from acceptance
// until the sequencer is back in idle, while a finished result may still wait in the output
// register. Each transaction runs from acceptance through S_EXEC to S_DONE; lookup adds
// S_LOOK, with one memory read and one 256-bit compare per held entry; get_oldest runs
// S_EXP_RD and S_EXP_CHK for each expired entry dropped, each drop needing a read and a
// 49-bit add and compare, and once more when an entry is left to report; rotate on a
// nonempty ring adds S_ROT_WR. A stalled result holds the sequencer until the output register
// frees. expiry_window is to be written through cfg_wr_en and cfg_wr_data by the user only
// while no transaction is in progress; the block does not enforce it. It resets to 1000.
`include "recent_digest_dedup_window_top_macros.svh"

module recent_digest_dedup_window_top #(
  parameter int DEPTH = rddw_pkg::DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [rddw_pkg::WIN_W-1:0]              cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [rddw_pkg::MODE_W-1:0]             in_mode,
  input  logic [rddw_pkg::WORD_W-1:0]             in_digest_w0,
  input  logic [rddw_pkg::WORD_W-1:0]             in_digest_w1,
  input  logic [rddw_pkg::WORD_W-1:0]             in_digest_w2,
  input  logic [rddw_pkg::WORD_W-1:0]             in_digest_w3,
  input  logic [rddw_pkg::TAG_W-1:0]              in_payload_tag,
  input  logic [rddw_pkg::TIME_W-1:0]             in_now_time,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [rddw_pkg::STATUS_W-1:0]           out_status,
  output logic                                    out_found,
  output logic [rddw_pkg::TAG_W-1:0]              out_oldest_tag,
  output logic [$clog2(DEPTH+1)-1:0]              out_entry_count
);

  import rddw_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  fsm_t                state_r, state_nxt;

  logic [WIN_W-1:0]    win_r;

  mode_t               mode_r;
  logic [DIGEST_W-1:0] dig_r;
  logic [TAG_W-1:0]    tag_r;
  logic [TIME_W-1:0]   now_r;

  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    lk_idx_r, lk_idx_nxt;
  logic                pend_r, pend_nxt;
  logic                hit_r, hit_nxt;

  status_t             res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;

  logic                out_valid_r;
  status_t             out_status_r;
  logic                out_found_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [CNT_W-1:0]    out_count_r;

  entry_t              ring_mem [DEPTH];
  entry_t              rd_data_r;
  entry_t              wr_data;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic                rd_en, wr_en;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic                dig_match;
  logic                expired;
  logic                empty;
  logic                full;
  logic                look_done;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_DONE) && out_free;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign look_done = (lk_idx_r == count_r);
  assign dig_match = pend_r && (rd_data_r.digest == dig_r);
  assign expired   = (EXP_W'(rd_data_r.arrival) + EXP_W'(win_r)) < EXP_W'(now_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_r)
          MODE_LOOKUP: state_nxt = S_LOOK;
          MODE_OLDEST: state_nxt = S_EXP_RD;
          MODE_ROTATE: state_nxt = empty ? S_DONE : S_ROT_WR;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_LOOK: begin
        if (look_done) begin
          state_nxt = S_DONE;
        end
      end
      S_EXP_RD: begin
        state_nxt = empty ? S_DONE : S_EXP_CHK;
      end
      S_EXP_CHK: begin
        state_nxt = expired ? S_EXP_RD : S_DONE;
      end
      S_ROT_WR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    lk_idx_nxt     = lk_idx_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_tag_nxt    = res_tag_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = slot_add(head_r, count_r);
    wr_data        = rd_data_r;
    case (state_r)
      S_EXEC: begin
        res_status_nxt = STS_OK;
        res_found_nxt  = 1'b0;
        res_tag_nxt    = '0;
        case (mode_r)
          MODE_ADD: begin
            if (full) begin
              res_status_nxt = STS_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_data   = '{digest: dig_r, arrival: now_r, tag: tag_r};
              count_nxt = count_r + CNT_W'(1);
            end
          end
          MODE_LOOKUP: begin
            lk_idx_nxt = '0;
            pend_nxt   = 1'b0;
            hit_nxt    = 1'b0;
          end
          MODE_ROTATE: begin
            if (empty) begin
              res_status_nxt = STS_EMPTY;
            end else begin
              rd_en = 1'b1;
            end
          end
          MODE_POP: begin
            if (empty) begin
              res_status_nxt = STS_EMPTY;
            end else begin
              head_nxt  = slot_add(head_r, CNT_W'(1));
              count_nxt = count_r - CNT_W'(1);
            end
          end
          MODE_CLEAR: begin
            head_nxt  = '0;
            count_nxt = '0;
          end
          default: ;
        endcase
      end
      S_LOOK: begin
        hit_nxt = hit_r || dig_match;
        if (look_done) begin
          pend_nxt      = 1'b0;
          res_found_nxt = hit_r || dig_match;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = slot_add(head_r, lk_idx_r);
          lk_idx_nxt = lk_idx_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end
      end
      S_EXP_RD: begin
        if (empty) begin
          res_status_nxt = STS_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_EXP_CHK: begin
        if (expired) begin
          head_nxt  = slot_add(head_r, CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end else begin
          res_tag_nxt = rd_data_r.tag;
        end
      end
      S_ROT_WR: begin
        // back slot of the ring after the front leaves is head plus count
        wr_en    = 1'b1;
        head_nxt = slot_add(head_r, CNT_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WINDOW_RST;
      head_r      <= '0;
      count_r     <= '0;
      lk_idx_r    <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      lk_idx_r <= lk_idx_nxt;
      pend_r   <= pend_nxt;
      hit_r    <= hit_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_tag_r    <= res_tag_nxt;
    if (in_accept) begin
      mode_r <= mode_t'(in_mode);
      dig_r  <= {in_digest_w0, in_digest_w1, in_digest_w2, in_digest_w3};
      tag_r  <= in_payload_tag;
      now_r  <= in_now_time;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_tag_r    <= res_tag_r;
      out_count_r  <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_oldest_tag  = out_tag_r;
  assign out_entry_count = out_count_r;

  `RDDW_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "held count above depth")
  `RDDW_ASSERT_NEXT(a_accept_busy, in_accept, state_r != S_IDLE, "sequencer idle after accept")
  `RDDW_ASSERT_NEXT(a_idle_ring, state_r == S_IDLE, $stable(count_r) && $stable(head_r), "ring changed while idle")
  `RDDW_ASSERT_NOW(a_result_src, $rose(out_valid_r), $past(state_r == S_DONE), "result without completion")

endmodule
